// ----- src/sfr_pkg.sv -----
// shared types and constants for the sync frame receiver
package sfr_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CRC_W   = 16;
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // reset values of the crc configuration registers
  localparam logic [CRC_W-1:0] CRC_POLY_RST  = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_START_RST = 16'hFFFF;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_FIRST  = 3'd0,
    CFG_SYNC_SECOND = 3'd1,
    CFG_VERSION     = 3'd2,
    CFG_PAYLOAD_LIM = 3'd3,
    CFG_CRC_POLY    = 3'd4,
    CFG_CRC_START   = 3'd5
  } cfg_idx_t;

  // parser phases
  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_VERSION = 4'd2,
    PH_TYPE    = 4'd3,
    PH_SEQ_L   = 4'd4,
    PH_SEQ_H   = 4'd5,
    PH_LEN_L   = 4'd6,
    PH_LEN_H   = 4'd7,
    PH_PAYLOAD = 4'd8,
    PH_CRC_L   = 4'd9,
    PH_CRC_H   = 4'd10
  } phase_t;

  // result event codes
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PAYLOAD = 3'd1,
    EV_GOOD    = 3'd2,
    EV_CRCERR  = 3'd3,
    EV_SYNCLOS = 3'd4
  } event_t;

endpackage

// ----- src/sfr_crc_byte.sv -----
// one-byte msb-first crc16 update with programmable polynomial
module sfr_crc_byte (
  input  logic [sfr_pkg::CRC_W-1:0]  crc_in,
  input  logic [sfr_pkg::CRC_W-1:0]  poly,
  input  logic [sfr_pkg::BYTE_W-1:0] data,
  output logic [sfr_pkg::CRC_W-1:0]  crc_out
);
  import sfr_pkg::*;

  // eight shift-and-xor steps over one byte
  always_comb begin
    logic [CRC_W-1:0] c;
    c = crc_in ^ {data, {(CRC_W-BYTE_W){1'b0}}};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// ----- src/sync_frame_receiver_crc16.sv -----
// Byte-serial frame receiver: sync hunt, header parse, streaming CRC16 check.
// Each accepted input beat gives its result beat in the next cycle.
// Throughput: one beat per cycle while out_ready is high; the byte-wide CRC update
// and phase decode sit between the parser state registers and the result register.
// Reset (rst_n low, synchronous): hunting for the first sync byte, counters and
// held header fields zero, registers at their defaults, no result pending.
module sync_frame_receiver_crc16 (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sfr_pkg::BYTE_W-1:0]   in_rx_byte,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   out_event_res,
  output logic [sfr_pkg::BYTE_W-1:0]   out_payload_byte,
  output logic [sfr_pkg::BYTE_W-1:0]   out_frame_type,
  output logic [sfr_pkg::HALF_W-1:0]   out_frame_sequence,
  output logic [sfr_pkg::HALF_W-1:0]   out_frame_length,
  output logic [sfr_pkg::CNT_W-1:0]    out_good_count,
  output logic [sfr_pkg::CNT_W-1:0]    out_crc_fail_count,
  output logic [sfr_pkg::CNT_W-1:0]    out_sync_loss_count,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sfr_pkg::*;

  // configuration registers
  logic [BYTE_W-1:0] sync_first_r, sync_second_r, version_r;
  logic [HALF_W-1:0] payload_limit_r;
  logic [CRC_W-1:0]  crc_poly_r, crc_start_r;

  // parser state
  phase_t            phase_r, phase_nxt;
  logic [CRC_W-1:0]  crc_running_r, crc_running_nxt;
  logic [CRC_W-1:0]  crc_received_r, crc_received_nxt;
  logic [BYTE_W-1:0] type_held_r, type_held_nxt;
  logic [HALF_W-1:0] sequence_held_r, sequence_held_nxt;
  logic [HALF_W-1:0] length_held_r, length_held_nxt;
  logic [HALF_W-1:0] payload_seen_r, payload_seen_nxt;
  logic [CNT_W-1:0]  good_total_r, good_total_nxt;
  logic [CNT_W-1:0]  crc_fail_total_r, crc_fail_total_nxt;
  logic [CNT_W-1:0]  sync_loss_total_r, sync_loss_total_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  event_t            event_r, event_nxt;
  logic [BYTE_W-1:0] payload_byte_r, payload_byte_nxt;

  logic              in_fire;
  logic [BYTE_W-1:0] b;
  logic              hit_first, lose, restart;
  logic [HALF_W-1:0] len_full, seen_inc;
  logic [CRC_W-1:0]  crc_rx_full, crc_in, crc_new;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign b        = in_rx_byte;

  // header decode helpers
  assign hit_first   = (b == sync_first_r);
  assign len_full    = {b, length_held_r[BYTE_W-1:0]};
  assign seen_inc    = payload_seen_r + HALF_W'(1);
  assign crc_rx_full = {b, crc_received_r[BYTE_W-1:0]};

  // sync loss on a bad second sync byte, version or over-limit length
  always_comb begin
    case (phase_r)
      PH_SYNC2:   lose = (b != sync_second_r);
      PH_VERSION: lose = (b != version_r);
      PH_LEN_H:   lose = (len_full > payload_limit_r);
      default:    lose = 1'b0;
    endcase
  end

  // hunting phases and sync loss restart the crc from the start value
  assign restart = lose || !(phase_r inside {PH_SYNC2, PH_VERSION, PH_TYPE, PH_SEQ_L,
                                             PH_SEQ_H, PH_LEN_L, PH_LEN_H, PH_PAYLOAD,
                                             PH_CRC_L, PH_CRC_H});
  assign crc_in  = restart ? crc_start_r : crc_running_r;

  sfr_crc_byte u_crc (
    .crc_in  (crc_in),
    .poly    (crc_poly_r),
    .data    (b),
    .crc_out (crc_new)
  );

  // next phase
  always_comb begin
    phase_nxt = PH_SYNC1;
    if (lose) begin
      phase_nxt = hit_first ? PH_SYNC2 : PH_SYNC1;
    end else begin
      case (phase_r)
        PH_SYNC2:   phase_nxt = PH_VERSION;
        PH_VERSION: phase_nxt = PH_TYPE;
        PH_TYPE:    phase_nxt = PH_SEQ_L;
        PH_SEQ_L:   phase_nxt = PH_SEQ_H;
        PH_SEQ_H:   phase_nxt = PH_LEN_L;
        PH_LEN_L:   phase_nxt = PH_LEN_H;
        PH_LEN_H:   phase_nxt = (len_full == '0) ? PH_CRC_L : PH_PAYLOAD;
        PH_PAYLOAD: phase_nxt = (seen_inc >= length_held_r) ? PH_CRC_L : PH_PAYLOAD;
        PH_CRC_L:   phase_nxt = PH_CRC_H;
        PH_CRC_H:   phase_nxt = PH_SYNC1;
        default:    phase_nxt = hit_first ? PH_SYNC2 : PH_SYNC1;
      endcase
    end
  end

  // datapath and result for the current beat
  always_comb begin
    crc_running_nxt     = crc_running_r;
    crc_received_nxt    = crc_received_r;
    type_held_nxt       = type_held_r;
    sequence_held_nxt   = sequence_held_r;
    length_held_nxt     = length_held_r;
    payload_seen_nxt    = payload_seen_r;
    good_total_nxt      = good_total_r;
    crc_fail_total_nxt  = crc_fail_total_r;
    sync_loss_total_nxt = sync_loss_total_r;
    event_nxt           = EV_NONE;
    payload_byte_nxt    = '0;
    case (phase_r)
      PH_SYNC2, PH_VERSION, PH_TYPE, PH_SEQ_L, PH_SEQ_H, PH_LEN_L: begin
        if (!lose) begin
          crc_running_nxt = crc_new;
        end
      end
      PH_LEN_H: begin
        length_held_nxt  = len_full;
        payload_seen_nxt = '0;
        if (!lose) begin
          crc_running_nxt = crc_new;
        end
      end
      PH_PAYLOAD: begin
        crc_running_nxt  = crc_new;
        event_nxt        = EV_PAYLOAD;
        payload_byte_nxt = b;
        payload_seen_nxt = seen_inc;
      end
      PH_CRC_L: begin
        crc_received_nxt = {{(CRC_W-BYTE_W){1'b0}}, b};
      end
      PH_CRC_H: begin
        crc_received_nxt = crc_rx_full;
        if (crc_rx_full == crc_running_r) begin
          good_total_nxt = good_total_r + CNT_W'(1);
          event_nxt      = EV_GOOD;
        end else begin
          crc_fail_total_nxt = crc_fail_total_r + CNT_W'(1);
          event_nxt          = EV_CRCERR;
        end
      end
      default: begin
        if (hit_first) begin
          crc_running_nxt = crc_new;
        end
      end
    endcase
    // header field capture
    case (phase_r)
      PH_TYPE:  type_held_nxt     = b;
      PH_SEQ_L: sequence_held_nxt = {{(HALF_W-BYTE_W){1'b0}}, b};
      PH_SEQ_H: sequence_held_nxt = {b, sequence_held_r[BYTE_W-1:0]};
      PH_LEN_L: length_held_nxt   = {{(HALF_W-BYTE_W){1'b0}}, b};
      default:  ;
    endcase
    // sync loss, with immediate restart when the byte is the first sync byte
    if (lose) begin
      sync_loss_total_nxt = sync_loss_total_r + CNT_W'(1);
      event_nxt           = EV_SYNCLOS;
      crc_running_nxt     = hit_first ? crc_new : crc_running_r;
    end
  end

  // result valid tracking
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r    <= '0;
      sync_second_r   <= '0;
      version_r       <= '0;
      payload_limit_r <= '0;
      crc_poly_r      <= CRC_POLY_RST;
      crc_start_r     <= CRC_START_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first_r    <= cfg_wdata[BYTE_W-1:0];
        CFG_SYNC_SECOND: sync_second_r   <= cfg_wdata[BYTE_W-1:0];
        CFG_VERSION:     version_r       <= cfg_wdata[BYTE_W-1:0];
        CFG_PAYLOAD_LIM: payload_limit_r <= cfg_wdata[HALF_W-1:0];
        CFG_CRC_POLY:    crc_poly_r      <= cfg_wdata[CRC_W-1:0];
        CFG_CRC_START:   crc_start_r     <= cfg_wdata[CRC_W-1:0];
        default:         ;
      endcase
    end
  end

  // parser state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_SYNC1;
      crc_running_r     <= '0;
      crc_received_r    <= '0;
      type_held_r       <= '0;
      sequence_held_r   <= '0;
      length_held_r     <= '0;
      payload_seen_r    <= '0;
      good_total_r      <= '0;
      crc_fail_total_r  <= '0;
      sync_loss_total_r <= '0;
      out_valid_r       <= 1'b0;
      event_r           <= EV_NONE;
      payload_byte_r    <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        phase_r           <= phase_nxt;
        crc_running_r     <= crc_running_nxt;
        crc_received_r    <= crc_received_nxt;
        type_held_r       <= type_held_nxt;
        sequence_held_r   <= sequence_held_nxt;
        length_held_r     <= length_held_nxt;
        payload_seen_r    <= payload_seen_nxt;
        good_total_r      <= good_total_nxt;
        crc_fail_total_r  <= crc_fail_total_nxt;
        sync_loss_total_r <= sync_loss_total_nxt;
        event_r           <= event_nxt;
        payload_byte_r    <= payload_byte_nxt;
      end
    end
  end

  // held fields and counters only move on an accepted beat, with the result
  assign out_valid           = out_valid_r;
  assign out_event_res       = event_r;
  assign out_payload_byte    = payload_byte_r;
  assign out_frame_type      = type_held_r;
  assign out_frame_sequence  = sequence_held_r;
  assign out_frame_length    = length_held_r;
  assign out_good_count      = good_total_r;
  assign out_crc_fail_count  = crc_fail_total_r;
  assign out_sync_loss_count = sync_loss_total_r;

  // payload byte is zero unless the event carries one
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (event_r != EV_PAYLOAD)) |-> (payload_byte_r == '0))
    else $error("payload byte set without payload event");

  // good counter steps exactly with a good-frame event
  a_good_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (good_total_r == ($past(good_total_r) +
                 ((event_r == EV_GOOD) ? CNT_W'(1) : CNT_W'(0)))))
    else $error("good counter out of step with events");

  // sync loss counter steps exactly with a sync loss event
  a_loss_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (sync_loss_total_r == ($past(sync_loss_total_r) +
                 ((event_r == EV_SYNCLOS) ? CNT_W'(1) : CNT_W'(0)))))
    else $error("sync loss counter out of step with events");

  // payload phase is never left with the count short of the length
  a_payload_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (phase_r == PH_PAYLOAD) && (seen_inc < length_held_r))
      |=> (phase_r == PH_PAYLOAD))
    else $error("payload phase left early");

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the sync frame receiver with streaming crc16
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef logic [7:0] octet_q_t[$];

  // one expected result beat
  typedef struct packed {
    event_t      ev;
    logic [7:0]  pay;
    logic [7:0]  ftype;
    logic [15:0] seq;
    logic [15:0] len;
    logic [31:0] good;
    logic [31:0] crcf;
    logic [31:0] sloss;
  } rx_result_t;

  // stimulus shapes for the random part
  typedef enum int {
    FR_GOOD,
    FR_BADCRC,
    FR_BAD_SECOND,
    FR_BAD_VERSION,
    FR_OVER_LIMIT,
    FR_TRUNCATED,
    FR_NOISE
  } frame_kind_t;

  // parser mirror and queue of predicted result beats
  class frame_scoreboard;
    logic [7:0]  sync_first_r;
    logic [7:0]  sync_second_r;
    logic [7:0]  version_r;
    logic [15:0] limit_r;
    logic [15:0] poly_r;
    logic [15:0] start_r;

    phase_t      phase;
    logic [15:0] crc_run;
    logic [15:0] crc_rcv;
    logic [7:0]  type_h;
    logic [15:0] seq_h;
    logic [15:0] len_h;
    logic [15:0] seen;
    logic [31:0] good_n;
    logic [31:0] crcf_n;
    logic [31:0] sloss_n;

    rx_result_t  expected_q[$];
    int unsigned fail_n;

    function new();
      sync_first_r  = '0;
      sync_second_r = '0;
      version_r     = '0;
      limit_r       = '0;
      poly_r        = CRC_POLY_RST;
      start_r       = CRC_START_RST;
      phase         = PH_SYNC1;
      crc_run       = '0;
      crc_rcv       = '0;
      type_h        = '0;
      seq_h         = '0;
      len_h         = '0;
      seen          = '0;
      good_n        = '0;
      crcf_n        = '0;
      sloss_n       = '0;
      fail_n        = 0;
    endfunction

    // msb-first crc16 over one byte, no reflection
    function logic [15:0] crc_next(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
        if (c[15]) c = (c << 1) ^ poly_r;
        else       c = c << 1;
      end
      return c;
    endfunction

    function logic [15:0] crc_of(octet_q_t q);
      logic [15:0] c;
      c = start_r;
      foreach (q[i]) c = crc_next(c, q[i]);
      return c;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] val);
      case (idx)
        CFG_SYNC_FIRST:  sync_first_r  = val[7:0];
        CFG_SYNC_SECOND: sync_second_r = val[7:0];
        CFG_VERSION:     version_r     = val[7:0];
        CFG_PAYLOAD_LIM: limit_r       = val;
        CFG_CRC_POLY:    poly_r        = val;
        CFG_CRC_START:   start_r       = val;
        default: ;
      endcase
    endfunction

    // start a frame on the first sync byte, otherwise keep hunting
    function void start_or_hunt(logic [7:0] b);
      if (b == sync_first_r) begin
        crc_run = crc_next(start_r, b);
        phase   = PH_SYNC2;
      end else begin
        phase = PH_SYNC1;
      end
    endfunction

    function void lose_sync(logic [7:0] b);
      sloss_n++;
      start_or_hunt(b);
    endfunction

    // advance the parser by one accepted byte and queue its result
    function void note_byte(logic [7:0] b);
      rx_result_t r;
      r.ev  = EV_NONE;
      r.pay = '0;
      case (phase)
        PH_SYNC2: begin
          if (b == sync_second_r) begin
            crc_run = crc_next(crc_run, b);
            phase   = PH_VERSION;
          end else begin
            r.ev = EV_SYNCLOS;
            lose_sync(b);
          end
        end
        PH_VERSION: begin
          if (b == version_r) begin
            crc_run = crc_next(crc_run, b);
            phase   = PH_TYPE;
          end else begin
            r.ev = EV_SYNCLOS;
            lose_sync(b);
          end
        end
        PH_TYPE: begin
          crc_run = crc_next(crc_run, b);
          type_h  = b;
          phase   = PH_SEQ_L;
        end
        PH_SEQ_L: begin
          crc_run = crc_next(crc_run, b);
          seq_h   = {8'h00, b};
          phase   = PH_SEQ_H;
        end
        PH_SEQ_H: begin
          crc_run = crc_next(crc_run, b);
          seq_h   = {b, seq_h[7:0]};
          phase   = PH_LEN_L;
        end
        PH_LEN_L: begin
          crc_run = crc_next(crc_run, b);
          len_h   = {8'h00, b};
          phase   = PH_LEN_H;
        end
        PH_LEN_H: begin
          len_h = {b, len_h[7:0]};
          seen  = '0;
          if (len_h > limit_r) begin
            r.ev = EV_SYNCLOS;
            lose_sync(b);
          end else begin
            crc_run = crc_next(crc_run, b);
            phase   = (len_h == 16'd0) ? PH_CRC_L : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          crc_run = crc_next(crc_run, b);
          r.ev    = EV_PAYLOAD;
          r.pay   = b;
          seen    = seen + 16'd1;
          if (seen >= len_h) phase = PH_CRC_L;
        end
        PH_CRC_L: begin
          crc_rcv = {8'h00, b};
          phase   = PH_CRC_H;
        end
        PH_CRC_H: begin
          crc_rcv = {b, crc_rcv[7:0]};
          if (crc_rcv == crc_run) begin
            good_n++;
            r.ev = EV_GOOD;
          end else begin
            crcf_n++;
            r.ev = EV_CRCERR;
          end
          phase = PH_SYNC1;
        end
        default: start_or_hunt(b);
      endcase
      r.ftype = type_h;
      r.seq   = seq_h;
      r.len   = len_h;
      r.good  = good_n;
      r.crcf  = crcf_n;
      r.sloss = sloss_n;
      expected_q.push_back(r);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string msg);
      fail_n++;
      $display("mismatch: %s", msg);
    endtask

    // compare one result beat with the oldest prediction
    task check_result(logic [2:0] ev, logic [7:0] pay, logic [7:0] ftype,
                      logic [15:0] seq, logic [15:0] len, logic [31:0] good,
                      logic [31:0] crcf, logic [31:0] sloss);
      rx_result_t e;
      if (expected_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
        return;
      end
      e = expected_q.pop_front();
      if (ev !== e.ev)
        report_mismatch($sformatf("event %0d, want %0d", ev, e.ev));
      if (pay !== e.pay)
        report_mismatch($sformatf("payload_byte %0h, want %0h", pay, e.pay));
      if (ftype !== e.ftype)
        report_mismatch($sformatf("frame_type %0h, want %0h", ftype, e.ftype));
      if (seq !== e.seq)
        report_mismatch($sformatf("frame_sequence %0h, want %0h", seq, e.seq));
      if (len !== e.len)
        report_mismatch($sformatf("frame_length %0h, want %0h", len, e.len));
      if (good !== e.good)
        report_mismatch($sformatf("good_count %0d, want %0d", good, e.good));
      if (crcf !== e.crcf)
        report_mismatch($sformatf("crc_fail_count %0d, want %0d", crcf, e.crcf));
      if (sloss !== e.sloss)
        report_mismatch($sformatf("sync_loss_count %0d, want %0d", sloss, e.sloss));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_event_res;
  logic [7:0]  out_payload_byte;
  logic [7:0]  out_frame_type;
  logic [15:0] out_frame_sequence;
  logic [15:0] out_frame_length;
  logic [31:0] out_good_count;
  logic [31:0] out_crc_fail_count;
  logic [31:0] out_sync_loss_count;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  frame_scoreboard sb = new();
  int unsigned     bytes_sent = 0;
  int unsigned     cycles = 0;
  bit              in_burst = 1'b0;
  bit              out_burst = 1'b0;

  sync_frame_receiver_crc16 u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_event_res       (out_event_res),
    .out_payload_byte    (out_payload_byte),
    .out_frame_type      (out_frame_type),
    .out_frame_sequence  (out_frame_sequence),
    .out_frame_length    (out_frame_length),
    .out_good_count      (out_good_count),
    .out_crc_fail_count  (out_crc_fail_count),
    .out_sync_loss_count (out_sync_loss_count),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // result side: random stalls per beat, bursts without stalls now and then
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 49) == 0) out_burst = ~out_burst;
      gap = out_burst ? 0 : $urandom_range(0, 12);
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(out_event_res, out_payload_byte, out_frame_type,
                      out_frame_sequence, out_frame_length, out_good_count,
                      out_crc_fail_count, out_sync_loss_count);
    end
  end

  // one input beat, preceded by a random idle gap
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
  endtask

  // write every register; upper data bits of byte registers are random junk
  task automatic write_all(logic [7:0] s1, logic [7:0] s2, logic [7:0] ver,
                           logic [15:0] lim, logic [15:0] poly, logic [15:0] start);
    write_reg(CFG_SYNC_FIRST,  {8'($urandom), s1});
    write_reg(CFG_SYNC_SECOND, {8'($urandom), s2});
    write_reg(CFG_VERSION,     {8'($urandom), ver});
    write_reg(CFG_PAYLOAD_LIM, lim);
    write_reg(CFG_CRC_POLY,    poly);
    write_reg(CFG_CRC_START,   start);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // stop sending and wait for every predicted beat
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // byte that matches none of the header magic values
  function automatic logic [7:0] filler();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == sb.sync_first_r || b == sb.sync_second_r || b == sb.version_r);
    return b;
  endfunction

  // replacement for a magic byte, often the first sync byte to force a resync
  function automatic logic [7:0] wrong_byte(logic [7:0] orig);
    logic [7:0] alt;
    alt = ($urandom_range(0, 1) == 0) ? sb.sync_first_r : 8'($urandom);
    if (alt == orig) alt = ~orig;
    return alt;
  endfunction

  // get the parser back to hunting before a new frame
  task automatic fill_to_hunt();
    while (sb.phase != PH_SYNC1) send_byte(filler());
  endtask

  // build one frame of the given shape and send all or part of it
  task automatic send_frame(frame_kind_t kind);
    octet_q_t    fb;
    logic [15:0] len;
    logic [15:0] cap;
    logic [15:0] crc;
    logic [15:0] seq;
    logic [7:0]  b;
    int          stop;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 6)) begin
        b = 8'($urandom);
        if (b == sb.sync_first_r) b = ~b;
        send_byte(b);
      end
      return;
    end
    if (kind == FR_OVER_LIMIT && sb.limit_r == 16'hFFFF) kind = FR_BADCRC;
    cap = (sb.limit_r < 16'd8) ? sb.limit_r : 16'd8;
    if ($urandom_range(0, 15) == 0) cap = (sb.limit_r < 16'd48) ? sb.limit_r : 16'd48;
    len = 16'($urandom_range(0, cap));
    if (kind == FR_OVER_LIMIT) begin
      len = 16'($urandom_range(int'(sb.limit_r) + 1, 65535));
      // high length byte equal to the first sync byte restarts the hunt
      if ($urandom_range(0, 2) == 0 && {sb.sync_first_r, 8'hFF} > sb.limit_r)
        len = {sb.sync_first_r, 8'hFF};
    end
    seq = 16'($urandom);
    fb = {sb.sync_first_r, sb.sync_second_r, sb.version_r, 8'($urandom),
          seq[7:0], seq[15:8], len[7:0], len[15:8]};
    if (kind != FR_OVER_LIMIT) begin
      for (int i = 0; i < int'(len); i++) fb.push_back(8'($urandom));
    end
    crc = sb.crc_of(fb);
    if (kind == FR_BADCRC) crc ^= 16'($urandom_range(1, 65535));
    fb.push_back(crc[7:0]);
    fb.push_back(crc[15:8]);
    stop = fb.size();
    case (kind)
      FR_BAD_SECOND: begin
        fb[1] = wrong_byte(fb[1]);
        stop  = 2;
      end
      FR_BAD_VERSION: begin
        fb[2] = wrong_byte(fb[2]);
        stop  = 3;
      end
      FR_OVER_LIMIT: stop = 8;
      FR_TRUNCATED:  stop = $urandom_range(9, fb.size() - 1);
      default: ;
    endcase
    for (int i = 0; i < stop; i++) send_byte(fb[i]);
  endtask

  // main sequence
  initial begin
    octet_q_t     hdr;
    logic [15:0]  crc;
    logic [15:0]  lim;
    int unsigned  target;
    int           pick;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: false second sync, bad version that resyncs, oversize length
    // whose high byte resyncs, then a zero-length frame with extreme header
    write_all(8'hA5, 8'h5A, 8'h01, 16'd4, 16'h1021, 16'hFFFF);
    hdr = {8'hA5, 8'h5A, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
    crc = sb.crc_of(hdr);
    send_byte(8'hA5);
    send_byte(8'h00);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'h01);
    send_byte(8'h07);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hA5);
    for (int i = 1; i < hdr.size(); i++) send_byte(hdr[i]);
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
    drain();

    // random phases, first two at the register extremes
    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        write_all(8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000);
      end else if (p == 1) begin
        write_all(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      end else begin
        lim = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 20)) : 16'($urandom);
        write_all(8'($urandom), 8'($urandom), 8'($urandom), lim,
                  16'($urandom), 16'($urandom));
      end
      target = bytes_sent + 230;
      while (bytes_sent < target) begin
        fill_to_hunt();
        in_burst = ($urandom_range(0, 4) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 55)      send_frame(FR_GOOD);
        else if (pick < 70) send_frame(FR_BADCRC);
        else if (pick < 75) send_frame(FR_BAD_SECOND);
        else if (pick < 80) send_frame(FR_BAD_VERSION);
        else if (pick < 85) send_frame(FR_OVER_LIMIT);
        else if (pick < 90) send_frame(FR_TRUNCATED);
        else                send_frame(FR_NOISE);
      end
      in_burst = 1'b0;
      drain();
    end

    if (sb.fail_n == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
